// ----- rtl/percent_decoder_unit_assert.svh -----
// Assertion macros for the percent decoder unit.
// Included by the top level; depends on nothing else.
`ifndef PERCENT_DECODER_UNIT_ASSERT_SVH
`define PERCENT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define PDU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define PDU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pdu_pkg.sv -----
// Shared types and constants of the percent decoder unit.
// Used by the front end, the queue, the back end and the top level.
package pdu_pkg;

    // Characters with a special meaning in the escaped stream.
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam int unsigned HEX_SHIFT = 4;

    // Most bytes one input can cause.
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // Command queue between front and back end.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Held-state codes of the front end.
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // One command: the bytes that one input produces, in output order.
    typedef struct packed {
        logic [CNT_W-1:0]               cnt;
        logic                           end_flag;
        logic [MAX_RESULTS-1:0][7:0]    data;
    } cmd_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- rtl/pdu_front.sv -----
// Front end of the percent decoder unit: accepts input bytes, tracks the
// held escape state and turns each byte into a command. Depends on pdu_pkg.
module pdu_front
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  q_status_t   q_status,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held_digit_reg;
    logic [7:0] held_digit_next;

    logic       accept;
    logic       in_hex;
    logic       fresh_hold;
    logic [7:0] fresh_byte;
    logic [7:0] decoded;
    cmd_t       cmd;

    // Value of a hex digit; non-digits map to zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c inside {[8'h30:8'h39]}) begin
                v = c - 8'h30;
            end else if (c inside {[8'h41:8'h46]}) begin
                v = c - 8'h41 + 8'd10;
            end else if (c inside {[8'h61:8'h66]}) begin
                v = c - 8'h61 + 8'd10;
            end
            return v[3:0];
        end
    endfunction

    // The front end takes a byte whenever the queue has room.
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Classification of the incoming byte.
    assign in_hex     = in_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    assign fresh_hold = (in_byte == PCT_CHAR) && !in_end;
    assign fresh_byte = (in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;
    assign decoded    = {hex_value(held_digit_reg), hex_value(in_byte)};

    // Build the command and the next held state.
    always_comb
    begin
        cmd             = '0;
        cmd.end_flag    = in_end;
        held_count_next = HELD_NONE;
        held_digit_next = held_digit_reg;
        case (held_count_reg)
            HELD_PCT:
            begin
                if (in_hex) begin
                    if (in_end) begin
                        cmd.cnt     = CNT_W'(2);
                        cmd.data[0] = PCT_CHAR;
                        cmd.data[1] = in_byte;
                    end else begin
                        held_count_next = HELD_DIGIT;
                        held_digit_next = in_byte;
                    end
                end else begin
                    // Failed escape: literal percent, then a fresh scan.
                    cmd.data[0]     = PCT_CHAR;
                    cmd.data[1]     = fresh_byte;
                    cmd.cnt         = fresh_hold ? CNT_W'(1) : CNT_W'(2);
                    held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                if (in_hex) begin
                    cmd.cnt     = CNT_W'(1);
                    cmd.data[0] = decoded;
                end else begin
                    // Failed escape after one digit: flush both, then rescan.
                    cmd.data[0]     = PCT_CHAR;
                    cmd.data[1]     = held_digit_reg;
                    cmd.data[2]     = fresh_byte;
                    cmd.cnt         = fresh_hold ? CNT_W'(2) : CNT_W'(3);
                    held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
                end
            end
            default:
            begin
                cmd.data[0]     = fresh_byte;
                cmd.cnt         = fresh_hold ? CNT_W'(0) : CNT_W'(1);
                held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
            end
        endcase
    end

    // Only bytes that produce output go into the queue.
    assign q_push = accept && (cmd.cnt != '0);
    assign q_cmd  = cmd;

    // Held escape state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg <= HELD_NONE;
            held_digit_reg <= 8'd0;
        end else if (accept) begin
            held_count_reg <= held_count_next;
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

// ----- rtl/pdu_queue.sv -----
// Short command queue between front and back end of the percent decoder.
// Depends on pdu_pkg.
module pdu_queue
    import pdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       pop_cmd,
    output q_status_t  status
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // Occupancy follows the push and pop transfers.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/pdu_back.sv -----
// Back end of the percent decoder unit: takes commands from the queue and
// sends their bytes out one per transfer. Depends on pdu_pkg.
module pdu_back
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_status,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        string_end
);

    cmd_t             cmd_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             busy_reg;
    logic             busy_next;
    logic             out_xfer;
    logic             is_last;

    assign out_valid  = busy_reg;
    assign out_xfer   = busy_reg && out_ready;
    assign is_last    = (idx_reg == cmd_reg.cnt - CNT_W'(1));
    assign run_last   = is_last;
    assign string_end = is_last && cmd_reg.end_flag;

    // Byte selected by the position within the current command.
    always_comb
    begin
        case (idx_reg)
            CNT_W'(0): out_byte = cmd_reg.data[0];
            CNT_W'(1): out_byte = cmd_reg.data[1];
            CNT_W'(2): out_byte = cmd_reg.data[2];
            default:   out_byte = cmd_reg.data[0];
        endcase
    end

    // Load a new command when idle or when the current one finishes.
    assign q_pop = !q_status.empty && (!busy_reg || (out_xfer && is_last));

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (q_pop) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (out_xfer) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // Current command.
    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
    end

endmodule

// ----- rtl/percent_decoder_unit.sv -----
// Percent decoder unit: streaming URL form decoder. It takes one escaped
// byte per transfer and sends out decoded bytes; "%hh" becomes one byte,
// "+" becomes a space, and a broken escape is passed through literally.
// An input byte that yields at most one output byte is taken every cycle
// while the command queue has room; a byte that yields more than one output
// byte holds the single output port until all are sent, and a two-entry
// command queue lets input run ahead meanwhile. A decoded byte passes
// through a queue entry and the back end's command register before output.
// Depends on pdu_pkg, pdu_front, pdu_queue, pdu_back and the assertion header.
`include "percent_decoder_unit_assert.svh"

module percent_decoder_unit
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        string_end
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    // Input side: escape tracking and command building.
    pdu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_end   (in_end),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Decoupling queue.
    pdu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // Output side: byte sequencing.
    pdu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

    // Checks on the internal handoff and output marking.
    `PDU_ASSERT_IMP(a_push_not_full, clk, rst_n, q_push, !q_status.full, "push into full queue")
    `PDU_ASSERT_IMP(a_pop_not_empty, clk, rst_n, q_pop, !q_status.empty, "pop from empty queue")
    `PDU_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid && string_end, run_last,
        "string end on a byte that is not last of its run")
    `PDU_ASSERT_NXT(a_end_queued, clk, rst_n, in_valid && in_ready && in_end,
        !q_status.empty, "final byte of a string produced no command")

endmodule
